// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OVERFLOW    = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW   = 3'd2;
  localparam logic [2:0] ST_DIVZERO     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] answer;
    logic [2:0]        status;
  } out_beat_t;

endpackage

// ===== rtl/postfix_stack_evaluator.sv =====
// Postfix evaluator: stack held in a RAM with a registered read port, read-modify-write sequencer.
// Operand or rejected beats are handled in S_IDLE; + - * pass S_RD1, S_RD2 and S_EXEC; / adds S_DIV (8-step divider).
// A beat with the end mark then passes S_FINISH and S_FREAD, which waits for the result register to free up.
// One beat is worked on at a time; the input is stalled until the sequencer is idle.
// Reset empties the stack pointer and clears the error; stack RAM contents are not reset.
`timescale 1ns / 1ps
module postfix_stack_evaluator import pse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned TW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RD1    = 7'b0000010,
    S_RD2    = 7'b0000100,
    S_EXEC   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_FREAD  = 7'b1000000
  } state_e;

  logic [7:0] mem [STACK_DEPTH];
  logic [7:0] rdata_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic we;

  state_e state_q, state_d;
  logic [TW-1:0] top_q, top_d;
  logic [2:0] err_q, err_d;
  logic [7:0] sym_q, sym_d;
  logic eoe_q, eoe_d;
  logic [7:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic [8:0] rem_q, rem_d;
  logic [7:0] dq_q, dq_d, dvs_q, dvs_d;
  logic [2:0] cnt_q, cnt_d;
  logic neg_q, neg_d;
  logic out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  logic [TW-1:0] top_m1, top_m2;
  logic [15:0] prod;
  logic [8:0] rem_s, rem_sub;
  logic qbit;
  logic [7:0] q_next;
  logic out_free;
  logic in_acc;

  assign top_m1 = top_q - TW'(1);
  assign top_m2 = top_q - TW'(2);
  assign rd_addr = (state_q == S_RD1) ? top_m2[AW-1:0] : top_m1[AW-1:0];
  assign prod = {8'h00, lhs_q} * {8'h00, rhs_q};
  assign rem_s = {rem_q[7:0], dq_q[7]};
  assign rem_sub = rem_s - {1'b0, dvs_q};
  assign qbit = !rem_sub[8];
  assign q_next = {dq_q[6:0], qbit};
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc = in_valid_i && (state_q == S_IDLE);

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    top_d = top_q;
    err_d = err_q;
    sym_d = sym_q;
    eoe_d = eoe_q;
    lhs_d = lhs_q;
    rhs_d = rhs_q;
    rem_d = rem_q;
    dq_d = dq_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we = 1'b0;
    wr_addr = top_m2[AW-1:0];
    wr_data = 8'h00;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sym_d = in_beat_i.symbol;
          eoe_d = in_beat_i.end_of_expression;
          state_d = in_beat_i.end_of_expression ? S_FINISH : S_IDLE;
          if (err_q == ST_OK) begin
            if (in_beat_i.symbol == CH_PLUS || in_beat_i.symbol == CH_MINUS ||
                in_beat_i.symbol == CH_MUL || in_beat_i.symbol == CH_DIV) begin
              if (top_q < TW'(2)) begin
                err_d = ST_UNDERFLOW;
              end else begin
                state_d = S_RD1;
              end
            end else if (in_beat_i.symbol == CH_DOLLAR ||
                         in_beat_i.symbol == CH_CARET) begin
              err_d = ST_UNSUPPORTED;
            end else if (top_q == TW'(STACK_DEPTH)) begin
              err_d = ST_OVERFLOW;
            end else begin
              we = 1'b1;
              wr_addr = top_q[AW-1:0];
              wr_data = in_beat_i.symbol - CH_ZERO;
              top_d = top_q + TW'(1);
            end
          end
        end
      end
      S_RD1: begin
        rhs_d = rdata_q;
        state_d = S_RD2;
      end
      S_RD2: begin
        lhs_d = rdata_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = eoe_q ? S_FINISH : S_IDLE;
        if (sym_q == CH_DIV) begin
          if (rhs_q == 8'h00) begin
            err_d = ST_DIVZERO;
            top_d = top_m2;
          end else begin
            rem_d = 9'h000;
            dq_d = lhs_q[7] ? 8'h00 - lhs_q : lhs_q;
            dvs_d = rhs_q[7] ? 8'h00 - rhs_q : rhs_q;
            neg_d = lhs_q[7] ^ rhs_q[7];
            cnt_d = 3'd0;
            state_d = S_DIV;
          end
        end else begin
          we = 1'b1;
          if (sym_q == CH_PLUS) begin
            wr_data = lhs_q + rhs_q;
          end else if (sym_q == CH_MINUS) begin
            wr_data = lhs_q - rhs_q;
          end else begin
            wr_data = prod[7:0];
          end
          top_d = top_m1;
        end
      end
      S_DIV: begin
        rem_d = qbit ? rem_sub : rem_s;
        dq_d = q_next;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          we = 1'b1;
          wr_data = neg_q ? 8'h00 - q_next : q_next;
          top_d = top_m1;
          state_d = eoe_q ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        state_d = S_FREAD;
      end
      S_FREAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q != ST_OK) begin
            out_d.answer = 8'sh00;
            out_d.status = err_q;
          end else if (top_q == TW'(0)) begin
            out_d.answer = 8'sh00;
            out_d.status = ST_UNDERFLOW;
          end else begin
            out_d.answer = rdata_q;
            out_d.status = ST_OK;
          end
          top_d = TW'(0);
          err_d = ST_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q <= '0;
      err_q <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q <= top_d;
      err_q <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    eoe_q <= eoe_d;
    lhs_q <= lhs_d;
    rhs_q <= rhs_d;
    rem_q <= rem_d;
    dq_q <= dq_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    out_q <= out_d;
  end

endmodule
